>>> src/jsu_pkg.sv
// shared types and character constants for the json string unescaper
package jsu_pkg;

	localparam int ENTRY_BYTES = 5;

	localparam logic [7:0] CH_BSLASH = 8'h5c;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_N      = 8'h6e;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_U      = 8'h75;
	localparam logic [7:0] CH_LF     = 8'h0a;
	localparam logic [7:0] CH_CR     = 8'h0d;
	localparam logic [7:0] CH_TAB    = 8'h09;

	localparam logic [7:0] UTF8_LEAD2 = 8'hc0;
	localparam logic [7:0] UTF8_LEAD3 = 8'he0;
	localparam logic [7:0] UTF8_CONT  = 8'h80;
	localparam logic [15:0] CODE_2BYTE = 16'h0080;
	localparam logic [15:0] CODE_3BYTE = 16'h0800;

	// output bytes caused by one input byte
	typedef struct packed {
		logic [ENTRY_BYTES-1:0][7:0] data;
		logic [2:0]                  cnt;
		logic                        last;
	} entry_t;

	typedef struct packed {
		logic   valid;
		entry_t entry;
	} push_t;

endpackage

>>> src/jsu_front.sv
// front end: accepts input bytes, tracks escape state and builds output entries
module jsu_front import jsu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_char,
	input  logic       in_last,
	input  logic       q_full,
	output push_t      push
);

	typedef enum logic [2:0] {
		MODE_NORMAL = 3'b001,
		MODE_BSLASH = 3'b010,
		MODE_HEX    = 3'b100
	} mode_t;

	function automatic logic is_simple(input logic [7:0] c);
		return (c == CH_BSLASH) || (c == CH_QUOTE) || (c == CH_N) || (c == CH_R) ||
			(c == CH_T);
	endfunction

	function automatic logic [7:0] simple_byte(input logic [7:0] c);
		logic [7:0] b;
		unique case (c)
			CH_N: b = CH_LF;
			CH_R: b = CH_CR;
			CH_T: b = CH_TAB;
			default: b = c;
		endcase
		return b;
	endfunction

	function automatic logic hex_ok(input logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
			(c >= 8'h41 && c <= 8'h46);
	endfunction

	function automatic logic [3:0] hex_val(input logic [7:0] c);
		logic [7:0] t;
		priority if (c <= 8'h39) begin
			t = c - 8'h30;
		end else if (c >= 8'h61) begin
			t = c - 8'h57;
		end else begin
			t = c - 8'h37;
		end
		return t[3:0];
	endfunction

	function automatic entry_t app(input entry_t e, input logic [7:0] b);
		entry_t r;
		r = e;
		r.data[r.cnt] = b;
		r.cnt = r.cnt + 3'd1;
		return r;
	endfunction

	function automatic entry_t app_code(input entry_t e, input logic [15:0] v);
		entry_t r;
		r = e;
		priority if (v < CODE_2BYTE) begin
			r = app(r, v[7:0]);
		end else if (v < CODE_3BYTE) begin
			r = app(r, UTF8_LEAD2 | {3'b000, v[10:6]});
			r = app(r, UTF8_CONT | {2'b00, v[5:0]});
		end else begin
			r = app(r, UTF8_LEAD3 | {4'b0000, v[15:12]});
			r = app(r, UTF8_CONT | {2'b00, v[11:6]});
			r = app(r, UTF8_CONT | {2'b00, v[5:0]});
		end
		return r;
	endfunction

	mode_t       mode_q, mode_d;
	logic [15:0] accum_q, accum_d, accum_n;
	logic [1:0]  count_q, count_d;
	logic        invalid_q, invalid_d, bad_n;
	logic [7:0]  held_q [3];
	logic        held_we;
	logic        accept;
	logic        c_hex_ok;
	logic [3:0]  c_hex;
	logic [7:0]  t0, t1, t2;
	logic [1:0]  tlen;
	entry_t      ent;

	assign in_ready = ~q_full;
	assign accept   = in_valid & in_ready;
	assign c_hex_ok = hex_ok(in_char);
	assign c_hex    = c_hex_ok ? hex_val(in_char) : 4'd0;
	assign accum_n  = {accum_q[11:0], c_hex};
	assign bad_n    = invalid_q | ~c_hex_ok;

	always_comb begin
		t0 = in_char;
		t1 = in_char;
		t2 = in_char;
		tlen = 2'd1;
		unique case (count_q)
			2'd0: begin
				tlen = 2'd1;
			end
			2'd1: begin
				t0 = held_q[0];
				tlen = 2'd2;
			end
			default: begin
				t0 = held_q[0];
				t1 = held_q[1];
				tlen = 2'd3;
			end
		endcase
	end

	always_comb begin
		ent = '0;
		mode_d = mode_q;
		accum_d = accum_q;
		count_d = count_q;
		invalid_d = invalid_q;
		held_we = 1'b0;
		unique case (mode_q)
			MODE_NORMAL: begin
				if (in_char == CH_BSLASH && !in_last) begin
					mode_d = MODE_BSLASH;
				end else begin
					ent = app(ent, in_char);
				end
			end
			MODE_BSLASH: begin
				if (is_simple(in_char)) begin
					ent = app(ent, simple_byte(in_char));
					mode_d = MODE_NORMAL;
				end else if (in_char == CH_U && !in_last) begin
					mode_d = MODE_HEX;
					count_d = 2'd0;
					accum_d = '0;
					invalid_d = 1'b0;
				end else begin
					ent = app(ent, CH_BSLASH);
					ent = app(ent, in_char);
					mode_d = MODE_NORMAL;
				end
			end
			MODE_HEX: begin
				accum_d = accum_n;
				invalid_d = bad_n;
				if (count_q != 2'd3) begin
					if (in_last) begin
						// cut short: replay backslash, u, the held characters and the final character
						ent = app(ent, CH_BSLASH);
						ent = app(ent, CH_U);
						if (tlen != 2'd1 && t0 == CH_BSLASH && is_simple(t1)) begin
							ent = app(ent, simple_byte(t1));
							if (tlen == 2'd3) ent = app(ent, t2);
						end else begin
							ent = app(ent, t0);
							if (tlen == 2'd3 && t1 == CH_BSLASH && is_simple(t2)) begin
								ent = app(ent, simple_byte(t2));
							end else begin
								if (tlen != 2'd1) ent = app(ent, t1);
								if (tlen == 2'd3) ent = app(ent, t2);
							end
						end
					end else begin
						held_we = 1'b1;
						count_d = count_q + 2'd1;
					end
				end else begin
					if (bad_n) begin
						ent = app(ent, CH_BSLASH);
					end else begin
						ent = app_code(ent, accum_n);
					end
					mode_d = MODE_NORMAL;
					count_d = 2'd0;
					accum_d = '0;
					invalid_d = 1'b0;
				end
			end
			default: begin
				mode_d = MODE_NORMAL;
			end
		endcase
		if (in_last) begin
			mode_d = MODE_NORMAL;
			count_d = 2'd0;
			accum_d = '0;
			invalid_d = 1'b0;
		end
		ent.last = in_last;
	end

	assign push.valid = accept & (ent.cnt != 3'd0);
	assign push.entry = ent;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_NORMAL;
			accum_q <= '0;
			count_q <= '0;
			invalid_q <= 1'b0;
		end else if (accept) begin
			mode_q <= mode_d;
			accum_q <= accum_d;
			count_q <= count_d;
			invalid_q <= invalid_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && held_we) begin
			held_q[count_q] <= in_char;
		end
	end

endmodule

>>> src/jsu_queue.sv
// short queue of output entries between front and back
module jsu_queue import jsu_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic   clk,
	input  logic   arst_n,
	input  push_t  push,
	input  logic   pop,
	output logic   full,
	output logic   head_valid,
	output entry_t head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	entry_t        mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full       = (count_q == CW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push.valid) begin
			mem_q[wr_ptr_q] <= push.entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + CW'(push.valid) - CW'(pop);
		end
	end

endmodule

>>> src/jsu_back.sv
// back end: serializes queued entries into one output byte per transfer
module jsu_back import jsu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       head_valid,
	input  entry_t     head,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_data,
	output logic       out_last
);

	logic [2:0] idx_q;
	logic       valid_q;
	logic [7:0] data_q;
	logic       last_q;
	logic       load;
	logic       end_of_entry;

	assign load         = head_valid & (~valid_q | out_ready);
	assign end_of_entry = (idx_q == head.cnt - 3'd1);
	assign pop          = load & end_of_entry;

	assign out_valid = valid_q;
	assign out_data  = data_q;
	assign out_last  = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q <= '0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q <= end_of_entry ? 3'd0 : idx_q + 3'd1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= head.data[idx_q];
			last_q <= head.last & end_of_entry;
		end
	end

endmodule

>>> src/json_string_unescaper_top.sv
// top level of the json string unescaper
// The block takes one escaped string character per input transfer and can accept
// a new one every cycle while its entry queue has room. Each character yields zero
// to five output bytes, which are stored together as one queue entry (QUEUE_DEPTH
// entries) and sent out one byte per cycle by the output stage while the receiver
// is ready, so the sustained input rate is one character per cycle as long as
// characters average at most one output byte; longer bursts (utf-8 sequences,
// strings cut short inside a \u escape) are absorbed by the queue and then throttle
// the input. Each result passes through the queue and then the output register.
module json_string_unescaper_top import jsu_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,  // in_byte
	input  logic       s_axis_tlast,
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,  // out_byte
	output logic       m_axis_tlast
);

	push_t  push;
	logic   q_full;
	logic   head_valid;
	entry_t head;
	logic   pop;

	jsu_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_char  (s_axis_tdata),
		.in_last  (s_axis_tlast),
		.q_full   (q_full),
		.push     (push)
	);

	jsu_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.pop        (pop),
		.full       (q_full),
		.head_valid (head_valid),
		.head       (head)
	);

	jsu_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_data   (m_axis_tdata),
		.out_last   (m_axis_tlast)
	);

endmodule

>>> src/jsu_checker.sv
// port-level checker for the json string unescaper and its bind
module jsu_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_axis_tvalid,
	input logic       s_axis_tready,
	input logic [7:0] s_axis_tdata,
	input logic       s_axis_tlast,
	input logic       m_axis_tvalid,
	input logic       m_axis_tready,
	input logic [7:0] m_axis_tdata,
	input logic       m_axis_tlast
);

	logic        in_xfer, out_xfer;
	logic [15:0] strings_open_q;
	logic [15:0] byte_credit_q;

	assign in_xfer  = s_axis_tvalid & s_axis_tready;
	assign out_xfer = m_axis_tvalid & m_axis_tready;

	// strings accepted but not yet finished on the output, and the output byte credit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strings_open_q <= '0;
			byte_credit_q <= '0;
		end else begin
			strings_open_q <= strings_open_q + 16'(in_xfer & s_axis_tlast) -
				16'(out_xfer & m_axis_tlast);
			byte_credit_q <= byte_credit_q + (in_xfer ? 16'd5 : 16'd0) - 16'(out_xfer);
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("output changed while stalled");

	a_done_has_string: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer && m_axis_tlast |-> strings_open_q != 16'd0 || (in_xfer && s_axis_tlast))
		else $error("string end sent without a final input");

	a_byte_budget: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer |-> byte_credit_q != 16'd0)
		else $error("more output bytes than five per input");

	a_final_flushes: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && s_axis_tlast |=> ##1 m_axis_tvalid)
		else $error("no output after a final character");

endmodule

bind json_string_unescaper_top jsu_checker u_jsu_checker (.*);

>>> sim/json_string_unescaper_checker.sv
`timescale 1ns / 1ps
// checker for the json string unescaper: predicts output bytes from input transfers and compares
module json_string_unescaper_checker import jsu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	input  logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,  // in_byte
	input  logic       s_axis_tlast,
	input  logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	input  logic [7:0] m_axis_tdata,  // out_byte
	input  logic       m_axis_tlast,
	output int         errors,
	output int         pending
);

	localparam int REPORT_LIMIT = 50;

	typedef enum logic [1:0] {ESC_NONE, ESC_BSLASH, ESC_HEX} esc_mode_t;

	esc_mode_t   esc_mode;
	logic [15:0] code_acc;
	logic [7:0]  held [3];
	int          held_n;
	bit          code_bad;

	logic [7:0]  tail_chars [6];
	int          tail_len;

	logic [7:0]  exp_data [$];
	logic        exp_last [$];
	int          fails;

	function void clear_state();
		esc_mode = ESC_NONE;
		code_acc = 16'h0000;
		held_n   = 0;
		code_bad = 1'b0;
	endfunction

	function automatic bit hex_value(input logic [7:0] c, output logic [3:0] v);
		v = 4'h0;
		if (c >= "0" && c <= "9") begin
			v = 4'(c - "0");
			return 1'b1;
		end
		if (c >= "a" && c <= "f") begin
			v = 4'(c - "a" + 8'd10);
			return 1'b1;
		end
		if (c >= "A" && c <= "F") begin
			v = 4'(c - "A" + 8'd10);
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic bit short_escape(input logic [7:0] c, output logic [7:0] b);
		b = 8'h00;
		case (c)
			CH_BSLASH: b = CH_BSLASH;
			CH_QUOTE:  b = CH_QUOTE;
			CH_N:      b = CH_LF;
			CH_R:      b = CH_CR;
			CH_T:      b = CH_TAB;
			default:   return 1'b0;
		endcase
		return 1'b1;
	endfunction

	function void expect_byte(input logic [7:0] b);
		exp_data = {exp_data, b};
		exp_last = {exp_last, 1'b0};
	endfunction

	// utf-8 encoding of one 16-bit code unit
	function void expect_code(input logic [15:0] v);
		if (v < CODE_2BYTE) begin
			expect_byte(v[7:0]);
		end else if (v < CODE_3BYTE) begin
			expect_byte(UTF8_LEAD2 | {3'b000, v[10:6]});
			expect_byte(UTF8_CONT | {2'b00, v[5:0]});
		end else begin
			expect_byte(UTF8_LEAD3 | {4'h0, v[15:12]});
			expect_byte(UTF8_CONT | {2'b00, v[11:6]});
			expect_byte(UTF8_CONT | {2'b00, v[5:0]});
		end
	endfunction

	// end of string: replay whatever was pending plus the last character
	function void expect_tail();
		int i;
		logic [7:0] b;
		logic [15:0] v;
		logic [3:0] d;
		bit ok;
		i = 0;
		while (i < tail_len) begin
			if (tail_chars[i] == CH_BSLASH && i + 1 < tail_len) begin
				if (short_escape(tail_chars[i + 1], b)) begin
					expect_byte(b);
					i += 2;
				end else if (tail_chars[i + 1] == CH_U && i + 5 < tail_len) begin
					v = 16'h0000;
					ok = 1'b1;
					for (int k = 0; k < 4; k++) begin
						if (!hex_value(tail_chars[i + 2 + k], d))
							ok = 1'b0;
						v = {v[11:0], d};
					end
					if (ok)
						expect_code(v);
					else
						expect_byte(CH_BSLASH);
					i += 6;
				end else begin
					expect_byte(CH_BSLASH);
					i += 1;
				end
			end else begin
				expect_byte(tail_chars[i]);
				i += 1;
			end
		end
	endfunction

	function void unescape_char(input logic [7:0] c, input logic fin);
		logic [7:0] b;
		logic [3:0] d;
		int first;
		first = exp_data.size();
		if (fin) begin
			tail_len = 0;
			if (esc_mode == ESC_BSLASH) begin
				tail_chars[0] = CH_BSLASH;
				tail_len = 1;
			end else if (esc_mode == ESC_HEX) begin
				tail_chars[0] = CH_BSLASH;
				tail_chars[1] = CH_U;
				tail_len = 2;
				for (int k = 0; k < held_n; k++) begin
					tail_chars[tail_len] = held[k];
					tail_len++;
				end
			end
			tail_chars[tail_len] = c;
			tail_len++;
			expect_tail();
			if (exp_data.size() > first)
				exp_last[exp_last.size() - 1] = 1'b1;
			clear_state();
		end else begin
			case (esc_mode)
				ESC_BSLASH: begin
					if (short_escape(c, b)) begin
						expect_byte(b);
						esc_mode = ESC_NONE;
					end else if (c == CH_U) begin
						esc_mode = ESC_HEX;
						held_n   = 0;
						code_acc = 16'h0000;
						code_bad = 1'b0;
					end else begin
						expect_byte(CH_BSLASH);
						expect_byte(c);
						esc_mode = ESC_NONE;
					end
				end
				ESC_HEX: begin
					if (!hex_value(c, d))
						code_bad = 1'b1;
					code_acc = {code_acc[11:0], d};
					if (held_n < 3) begin
						held[held_n] = c;
						held_n++;
					end else begin
						if (code_bad)
							expect_byte(CH_BSLASH);
						else
							expect_code(code_acc);
						clear_state();
					end
				end
				default: begin
					if (c == CH_BSLASH)
						esc_mode = ESC_BSLASH;
					else
						expect_byte(c);
				end
			endcase
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [7:0] want_data;
		logic want_last;
		if (!arst_n) begin
			clear_state();
			exp_data.delete();
			exp_last.delete();
			fails = 0;
			errors  <= 0;
			pending <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				unescape_char(s_axis_tdata, s_axis_tlast);
			if (m_axis_tvalid && m_axis_tready) begin
				if (exp_data.size() == 0) begin
					fails++;
					if (fails <= REPORT_LIMIT)
						$display("%0t: unexpected output transfer, expected none, got data %h last %b",
							$time, m_axis_tdata, m_axis_tlast);
				end else begin
					want_data = exp_data.pop_front();
					want_last = exp_last.pop_front();
					if (m_axis_tdata !== want_data) begin
						fails++;
						if (fails <= REPORT_LIMIT)
							$display("%0t: out_byte expected %h, got %h",
								$time, want_data, m_axis_tdata);
					end
					if (m_axis_tlast !== want_last) begin
						fails++;
						if (fails <= REPORT_LIMIT)
							$display("%0t: string_done expected %b, got %b",
								$time, want_last, m_axis_tlast);
					end
				end
			end
			errors  <= fails;
			pending <= exp_data.size();
		end
	end

endmodule

>>> sim/json_string_unescaper_top_tb.sv
`timescale 1ns / 1ps
// testbench top: feeds escaped strings to the unescaper, paces both sides and reports the verdict
module json_string_unescaper_top_tb;
	import jsu_pkg::*;

	localparam int RANDOM_ITEMS = 420;
	localparam int HOLD_CYCLES  = 300;
	localparam int HOLD_ITEMS   = 48;
	localparam int DRAIN_CYCLES = 30;
	localparam int CYCLE_LIMIT  = 1000000;

	logic       clk;
	logic       arst_n;
	logic       s_axis_tvalid;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata;
	logic       s_axis_tlast;
	logic       m_axis_tvalid;
	logic       m_axis_tready;
	logic [7:0] m_axis_tdata;
	logic       m_axis_tlast;

	int         errors;
	int         pending;
	int         cycles;
	int         directed_n;
	bit         hold_req;

	logic [7:0] char_q [$];
	bit         final_q [$];

	json_string_unescaper_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	json_string_unescaper_checker chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.errors        (errors),
		.pending       (pending)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function void push_char(input logic [7:0] c);
		char_q  = {char_q, c};
		final_q = {final_q, 1'b0};
	endfunction

	function void push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			push_char(s[i]);
	endfunction

	function void end_string();
		final_q[final_q.size() - 1] = 1'b1;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		if (n < 4'd10)
			return "0" + {4'h0, n};
		if ($urandom_range(0, 1) != 0)
			return "a" + {4'h0, n} - 8'd10;
		return "A" + {4'h0, n} - 8'd10;
	endfunction

	function automatic bit is_hex(input logic [7:0] c);
		return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
	endfunction

	function void push_code(input logic [15:0] v);
		push_char(CH_BSLASH);
		push_char(CH_U);
		push_char(hex_char(v[15:12]));
		push_char(hex_char(v[11:8]));
		push_char(hex_char(v[7:4]));
		push_char(hex_char(v[3:0]));
	endfunction

	// characters that may follow a \u cut short by the end of the string
	function automatic logic [7:0] tail_pick();
		case ($urandom_range(0, 5))
			0, 1:    return hex_char(4'($urandom_range(0, 15)));
			2:       return CH_BSLASH;
			3:       return CH_N;
			4:       return CH_U;
			default: return 8'($urandom);
		endcase
	endfunction

	function void add_token();
		int r;
		int bad;
		logic [15:0] v;
		logic [7:0] c;
		r = $urandom_range(0, 99);
		if (r < 35) begin
			push_char(8'($urandom));
		end else if (r < 50) begin
			push_char(CH_BSLASH);
			case ($urandom_range(0, 4))
				0:       push_char(CH_BSLASH);
				1:       push_char(CH_QUOTE);
				2:       push_char(CH_N);
				3:       push_char(CH_R);
				default: push_char(CH_T);
			endcase
		end else if (r < 75) begin
			case ($urandom_range(0, 3))
				0: v = 16'($urandom_range(0, CODE_2BYTE - 1));
				1: v = 16'($urandom_range(CODE_2BYTE, CODE_3BYTE - 1));
				2: v = 16'($urandom_range(CODE_3BYTE, 16'hffff));
				default: begin
					case ($urandom_range(0, 5))
						0:       v = 16'h0000;
						1:       v = CODE_2BYTE - 16'd1;
						2:       v = CODE_3BYTE - 16'd1;
						3:       v = CODE_3BYTE;
						4:       v = 16'hffff;
						default: v = 16'hd83d;
					endcase
				end
			endcase
			push_code(v);
		end else if (r < 85) begin
			bad = $urandom_range(0, 3);
			push_char(CH_BSLASH);
			push_char(CH_U);
			for (int k = 0; k < 4; k++) begin
				if (k == bad || $urandom_range(0, 5) == 0) begin
					c = 8'($urandom);
					if (is_hex(c))
						c = "g";
				end else begin
					c = hex_char(4'($urandom_range(0, 15)));
				end
				push_char(c);
			end
		end else if (r < 95) begin
			c = 8'($urandom);
			if (c == CH_BSLASH || c == CH_QUOTE || c == CH_N || c == CH_R || c == CH_T
				|| c == CH_U)
				c = "x";
			push_char(CH_BSLASH);
			push_char(c);
		end else begin
			push_text("u0A9fz");
		end
	endfunction

	function void build_directed();
		push_char(8'h00);
		push_text("\\n\\\"");
		push_char(8'hff);
		end_string();
		push_text("\\u07fF");
		end_string();
		push_text("\\uD83D\\q\\");
		end_string();
		push_text("\\u\\t");
		end_string();
	endfunction

	function void build_random();
		int n;
		int r;
		while (char_q.size() < directed_n + RANDOM_ITEMS) begin
			if ($urandom_range(0, 9) == 0) begin
				n = $urandom_range(1, 6);
				repeat (n) push_char(8'($urandom));
			end else begin
				n = $urandom_range(1, 8);
				repeat (n) add_token();
				r = $urandom_range(0, 99);
				if (r >= 85) begin
					push_char(CH_BSLASH);
				end else if (r >= 60) begin
					push_char(CH_BSLASH);
					push_char(CH_U);
					n = $urandom_range(0, 4);
					repeat (n) push_char(tail_pick());
				end
			end
			end_string();
		end
	endfunction

	task automatic send_char(input logic [7:0] c, input bit fin);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= c;
		s_axis_tlast  <= fin;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// receiver pacing, with one long hold-off on request
	initial begin
		int hold_left;
		int ready_run;
		int stall_left;
		hold_left  = 0;
		ready_run  = 0;
		stall_left = 0;
		m_axis_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				m_axis_tready <= 1'b0;
				hold_left--;
			end else if (ready_run > 0) begin
				m_axis_tready <= 1'b1;
				ready_run--;
			end else if (stall_left > 0) begin
				m_axis_tready <= 1'b0;
				stall_left--;
			end else begin
				ready_run  = $urandom_range(1, 24);
				stall_left = pick_gap();
				m_axis_tready <= 1'b1;
			end
		end
	end

	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		int gap;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = 8'h00;
		s_axis_tlast  = 1'b0;
		hold_req      = 1'b0;
		build_directed();
		directed_n = char_q.size();
		build_random();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < char_q.size(); i++) begin
			if (i == directed_n)
				hold_req = 1'b1;
			send_char(char_q[i], final_q[i]);
			if (i >= directed_n && i < directed_n + HOLD_ITEMS)
				gap = 0;
			else
				gap = pick_gap();
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
